// ----- sv/hmb_pkg.sv -----
`timescale 1ns / 1ps
// hmb_pkg: shared types, codes and the hexagonal neighbor function
// for the hex maze backtracker; no dependencies
package hmb_pkg;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;
  localparam int DIM_W        = 9;
  localparam int CFG_W        = 7;
  localparam int CFG_IDX_W    = 2;
  localparam int NUM_DIRS     = 6;
  localparam logic [5:0] ALL_WALLS = 6'h3F;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

  // item opcodes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // result events
  localparam logic [2:0] EV_CARVED  = 3'd0;
  localparam logic [2:0] EV_BACK    = 3'd1;
  localparam logic [2:0] EV_REJECT  = 3'd2;
  localparam logic [2:0] EV_DONE    = 3'd3;
  localparam logic [2:0] EV_STARTED = 3'd4;
  localparam logic [2:0] EV_WALLS   = 3'd5;

  // directions
  localparam logic [2:0] DIR_TOP   = 3'd0;
  localparam logic [2:0] DIR_UR    = 3'd1;
  localparam logic [2:0] DIR_LR    = 3'd2;
  localparam logic [2:0] DIR_BOT   = 3'd3;
  localparam logic [2:0] DIR_LL    = 3'd4;
  localparam logic [2:0] DIR_UL    = 3'd5;

  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
  } dims_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] nr;
    logic [7:0] nc;
  } nbr_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_SEED, S_IDLE, S_QRD, S_QOUT, S_TOPWAIT, S_NBR, S_DECIDE, S_NWAIT
  } state_t;

  // opposite direction, (d + 3) mod 6
  function automatic logic [2:0] opp_dir(input logic [2:0] d);
    logic [2:0] o;
    case (d)
      DIR_TOP: o = DIR_BOT;
      DIR_UR:  o = DIR_LL;
      DIR_LR:  o = DIR_UL;
      DIR_BOT: o = DIR_TOP;
      DIR_LL:  o = DIR_UR;
      DIR_UL:  o = DIR_LR;
      default: o = DIR_TOP;
    endcase
    return o;
  endfunction

  // neighbor of (r,c) in direction d inside the current grid
  function automatic nbr_t nbr_of(input logic [7:0] r, input logic [7:0] c,
                                  input logic [2:0] d, input dims_t dm);
    nbr_t n;
    logic signed [9:0] tr;
    logic signed [9:0] tc;
    logic even;
    logic ok;
    even = ~c[0];
    tr = signed'({2'b00, r});
    tc = signed'({2'b00, c});
    ok = 1'b1;
    case (d)
      DIR_TOP: tr = tr - 10'sd1;
      DIR_BOT: tr = tr + 10'sd1;
      DIR_UR: begin
        tc = tc + 10'sd1;
        if (!even) tr = tr - 10'sd1;
      end
      DIR_LR: begin
        tc = tc + 10'sd1;
        if (even) tr = tr + 10'sd1;
      end
      DIR_LL: begin
        tc = tc - 10'sd1;
        if (even) tr = tr + 10'sd1;
      end
      DIR_UL: begin
        tc = tc - 10'sd1;
        if (!even) tr = tr - 10'sd1;
      end
      default: ok = 1'b0;
    endcase
    n.ok = ok && (tr >= 10'sd0) && (tc >= 10'sd0)
        && (tr < signed'({1'b0, dm.rows})) && (tc < signed'({1'b0, dm.cols}));
    n.nr = tr[7:0];
    n.nc = tc[7:0];
    return n;
  endfunction

endpackage

// ----- sv/hmb_ram.sv -----
`timescale 1ns / 1ps
// hmb_ram: simple dual-port synchronous memory, one write and one read
// port, registered read data; no dependencies
module hmb_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/hmb_cfg.sv -----
`timescale 1ns / 1ps
// hmb_cfg: grid size registers and their saturation into 1..MAX
// depends on hmb_pkg
module hmb_cfg #(
  parameter int MAX_ROWS = hmb_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = hmb_pkg::DEF_MAX_COLS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hmb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hmb_pkg::CFG_W-1:0]     cfg_data,
  output hmb_pkg::dims_t                dims
);

  logic [hmb_pkg::CFG_W-1:0] maze_rows;
  logic [hmb_pkg::CFG_W-1:0] maze_cols;

  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      maze_rows <= hmb_pkg::CFG_W'(8);
      maze_cols <= hmb_pkg::CFG_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == hmb_pkg::REG_ROWS) maze_rows <= cfg_data;
      else if (cfg_index == hmb_pkg::REG_COLS) maze_cols <= cfg_data;
    end
  end

  // saturate into the stored grid
  always_comb begin
    if (maze_rows == '0) dims.rows = hmb_pkg::DIM_W'(1);
    else if (32'(maze_rows) > MAX_ROWS) dims.rows = hmb_pkg::DIM_W'(MAX_ROWS);
    else dims.rows = hmb_pkg::DIM_W'(maze_rows);
    if (maze_cols == '0) dims.cols = hmb_pkg::DIM_W'(1);
    else if (32'(maze_cols) > MAX_COLS) dims.cols = hmb_pkg::DIM_W'(MAX_COLS);
    else dims.cols = hmb_pkg::DIM_W'(maze_cols);
  end

endmodule

// ----- sv/hex_maze_backtracker.sv -----
`timescale 1ns / 1ps
// hex_maze_backtracker: depth-first hex maze generator around a cell memory
// and a path stack memory; depends on hmb_pkg, hmb_ram, hmb_cfg
//
//  channel   handshake                       payload
//  item in   start & !busy                   opcode, direction, query_row, query_col
//  result    result_valid (one cycle strobe) event_res, cell_row, cell_col,
//                                            carved_direction, wall_bits, path_depth
//  config    cfg_valid & cfg_ready           cfg_index, cfg_data
//
// start: a sweep over all MAX_ROWS*MAX_COLS cells (one per cycle), then the seed state
// query: cell read in S_QRD, result emitted from S_QOUT; step on empty stack: next cycle
// step: stack read, six neighbor visited reads through the single cell read
//   port, then decide, followed by a write-back state when carving
// after reset the same clearing sweep runs with busy high
// results are strobed for one cycle and cannot be stalled
module hex_maze_backtracker #(
  parameter int MAX_ROWS = hmb_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = hmb_pkg::DEF_MAX_COLS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    opcode,
  input  logic [2:0]                    direction,
  input  logic [5:0]                    query_row,
  input  logic [5:0]                    query_col,
  output logic                          result_valid,
  output logic [2:0]                    event_res,
  output logic [5:0]                    cell_row,
  output logic [5:0]                    cell_col,
  output logic [2:0]                    carved_direction,
  output logic [5:0]                    wall_bits,
  output logic [12:0]                   path_depth,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hmb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hmb_pkg::CFG_W-1:0]     cfg_data
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int ID_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int SC_W  = $clog2(CELLS + 1);
  localparam int SE_W  = RW + CW;
  localparam logic [6:0] CLEAR_WORD = {1'b0, hmb_pkg::ALL_WALLS};

  hmb_pkg::dims_t  dims;
  hmb_pkg::state_t state, state_next;

  // cell memory: {visited, walls}
  logic            cell_we;
  logic [ID_W-1:0] cell_waddr, cell_raddr;
  logic [6:0]      cell_wdata, cell_rdata;
  // path stack memory: {row, col}
  logic            stk_we;
  logic [ID_W-1:0] stk_waddr, stk_raddr;
  logic [SE_W-1:0] stk_wdata, stk_rdata;

  logic [SC_W-1:0] count, count_next;
  logic [ID_W-1:0] clr_addr;
  logic            seed_pending, seed_next;
  logic [2:0]      dir_q;
  logic [5:0]      qr_q, qc_q;
  logic            q_in;
  logic [RW-1:0]   top_r;
  logic [CW-1:0]   top_c;
  logic [2:0]      k;
  logic            pend_ok;
  logic [2:0]      pend_k;
  logic            open_acc, dir_free;
  logic [5:0]      top_walls_new;

  logic            acc;
  logic [2:0]      nsel;
  hmb_pkg::nbr_t   nb;
  logic [ID_W-1:0] nb_id, top_id;
  logic            pend_free;

  logic            emit;
  logic [2:0]      e_ev, e_dir;
  logic [5:0]      e_row, e_col, e_walls;

  hmb_cfg #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_cfg (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .dims
  );

  hmb_ram #(.WIDTH(7), .DEPTH(CELLS), .AW(ID_W)) u_cell_mem (
    .clk, .we(cell_we), .waddr(cell_waddr), .wdata(cell_wdata),
    .raddr(cell_raddr), .rdata(cell_rdata)
  );

  hmb_ram #(.WIDTH(SE_W), .DEPTH(CELLS), .AW(ID_W)) u_stack_mem (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  assign busy = (state != hmb_pkg::S_IDLE);
  assign acc  = start && !busy;

  // shared neighbor unit: drawn direction while deciding and writing back, else scan
  assign nsel   = ((state == hmb_pkg::S_DECIDE) || (state == hmb_pkg::S_NWAIT)) ? dir_q : k;
  assign nb     = hmb_pkg::nbr_of(8'(top_r), 8'(top_c), nsel, dims);
  assign nb_id  = ID_W'(int'(nb.nr) * MAX_COLS + int'(nb.nc));
  assign top_id = ID_W'(int'(top_r) * MAX_COLS + int'(top_c));
  assign pend_free = pend_ok && !cell_rdata[6];

  // next state, memory accesses and result
  always_comb begin
    state_next = state;
    count_next = count;
    seed_next  = seed_pending;
    cell_we    = 1'b0;
    cell_waddr = clr_addr;
    cell_wdata = CLEAR_WORD;
    cell_raddr = nb_id;
    stk_we     = 1'b0;
    stk_waddr  = ID_W'(count);
    stk_wdata  = {top_r, top_c};
    stk_raddr  = ID_W'(count - SC_W'(1));
    emit       = 1'b0;
    e_ev       = hmb_pkg::EV_DONE;
    e_row      = 6'(top_r);
    e_col      = 6'(top_c);
    e_dir      = 3'd0;
    e_walls    = cell_rdata[5:0];
    unique case (state)
      hmb_pkg::S_CLEAR: begin
        cell_we = 1'b1;
        if (32'(clr_addr) == CELLS - 1) begin
          state_next = seed_pending ? hmb_pkg::S_SEED : hmb_pkg::S_IDLE;
        end
      end
      hmb_pkg::S_SEED: begin
        cell_we    = 1'b1;
        cell_waddr = '0;
        cell_wdata = {1'b1, hmb_pkg::ALL_WALLS};
        stk_we     = 1'b1;
        stk_waddr  = '0;
        stk_wdata  = '0;
        count_next = SC_W'(1);
        seed_next  = 1'b0;
        emit       = 1'b1;
        e_ev       = hmb_pkg::EV_STARTED;
        e_row      = '0;
        e_col      = '0;
        e_walls    = hmb_pkg::ALL_WALLS;
        state_next = hmb_pkg::S_IDLE;
      end
      hmb_pkg::S_IDLE: begin
        if (acc) begin
          unique case (opcode)
            hmb_pkg::OP_START: begin
              seed_next  = 1'b1;
              state_next = hmb_pkg::S_CLEAR;
            end
            hmb_pkg::OP_STEP: begin
              if (count == '0) begin
                emit    = 1'b1;
                e_ev    = hmb_pkg::EV_DONE;
                e_row   = '0;
                e_col   = '0;
                e_walls = '0;
              end else begin
                state_next = hmb_pkg::S_TOPWAIT;
              end
            end
            default: state_next = hmb_pkg::S_QRD;
          endcase
        end
      end
      hmb_pkg::S_QRD: begin
        cell_raddr = ID_W'(int'(qr_q) * MAX_COLS + int'(qc_q));
        state_next = hmb_pkg::S_QOUT;
      end
      hmb_pkg::S_QOUT: begin
        emit       = 1'b1;
        e_ev       = hmb_pkg::EV_WALLS;
        e_row      = qr_q;
        e_col      = qc_q;
        e_walls    = q_in ? cell_rdata[5:0] : hmb_pkg::ALL_WALLS;
        state_next = hmb_pkg::S_IDLE;
      end
      hmb_pkg::S_TOPWAIT: begin
        state_next = hmb_pkg::S_NBR;
      end
      hmb_pkg::S_NBR: begin
        if (k == 3'(hmb_pkg::NUM_DIRS)) begin
          cell_raddr = top_id;
          state_next = hmb_pkg::S_DECIDE;
        end
      end
      hmb_pkg::S_DECIDE: begin
        if (!open_acc) begin
          count_next = count - SC_W'(1);
          emit       = 1'b1;
          e_ev       = hmb_pkg::EV_BACK;
          state_next = hmb_pkg::S_IDLE;
        end else if (dir_free && (32'(count) < CELLS)) begin
          cell_we    = 1'b1;
          cell_waddr = top_id;
          cell_wdata = {1'b1, cell_rdata[5:0] & ~(6'd1 << dir_q)};
          cell_raddr = nb_id;
          state_next = hmb_pkg::S_NWAIT;
        end else begin
          emit       = 1'b1;
          e_ev       = hmb_pkg::EV_REJECT;
          state_next = hmb_pkg::S_IDLE;
        end
      end
      hmb_pkg::S_NWAIT: begin
        cell_we    = 1'b1;
        cell_waddr = nb_id;
        cell_wdata = {1'b1, cell_rdata[5:0] & ~(6'd1 << hmb_pkg::opp_dir(dir_q))};
        stk_we     = 1'b1;
        stk_wdata  = {nb.nr[RW-1:0], nb.nc[CW-1:0]};
        count_next = count + SC_W'(1);
        emit       = 1'b1;
        e_ev       = hmb_pkg::EV_CARVED;
        e_dir      = dir_q;
        e_walls    = top_walls_new;
        state_next = hmb_pkg::S_IDLE;
      end
      default: state_next = hmb_pkg::S_IDLE;
    endcase
  end

  // carve target seen at decide, kept for the write-back check
  logic [7:0] carve_nr, carve_nc;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= hmb_pkg::S_CLEAR;
      count        <= '0;
      clr_addr     <= '0;
      seed_pending <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      seed_pending <= seed_next;
      result_valid <= emit;
      if (state == hmb_pkg::S_CLEAR) clr_addr <= clr_addr + ID_W'(1);
      else clr_addr <= '0;
    end
  end

  // item capture, neighbor scan and result registers
  always_ff @(posedge clk) begin
    if (acc) begin
      dir_q <= direction;
      qr_q  <= query_row;
      qc_q  <= query_col;
      q_in  <= (32'(query_row) < MAX_ROWS) && (32'(query_col) < MAX_COLS);
    end
    if (state == hmb_pkg::S_TOPWAIT) begin
      top_r    <= stk_rdata[SE_W-1:CW];
      top_c    <= stk_rdata[CW-1:0];
      k        <= '0;
      pend_ok  <= 1'b0;
      open_acc <= 1'b0;
      dir_free <= 1'b0;
    end
    if (state == hmb_pkg::S_NBR) begin
      k       <= k + 3'd1;
      pend_ok <= nb.ok;
      pend_k  <= k;
      if (k != 3'd0) begin
        if (pend_free) open_acc <= 1'b1;
        if (pend_k == dir_q) dir_free <= pend_free;
      end
    end
    if (state == hmb_pkg::S_DECIDE) begin
      top_walls_new <= cell_rdata[5:0] & ~(6'd1 << dir_q);
      carve_nr      <= nb.nr;
      carve_nc      <= nb.nc;
    end
    if (emit) begin
      event_res        <= e_ev;
      cell_row         <= e_row;
      cell_col         <= e_col;
      carved_direction <= e_dir;
      wall_bits        <= e_walls;
      path_depth       <= 13'(count_next);
    end
  end

  // carve target stays stable from decide to write-back
  a_carve_target: assert property (@(posedge clk) disable iff (rst)
    (state == hmb_pkg::S_NWAIT) |-> (nb.nr == carve_nr) && (nb.nc == carve_nc))
    else $error("carve target moved between decide and write-back");

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= CELLS)
    else $error("path stack count beyond capacity");

  a_carve_push: assert property (@(posedge clk) disable iff (rst)
    (emit && (e_ev == hmb_pkg::EV_CARVED)) |=> (count == $past(count) + SC_W'(1)))
    else $error("carve without push");

  a_clear_word: assert property (@(posedge clk) disable iff (rst)
    (state == hmb_pkg::S_CLEAR) |-> (cell_we && (cell_wdata == CLEAR_WORD)))
    else $error("clearing sweep writes wrong word");

  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(acc) || $past(busy)))
    else $error("result without an item in flight");

endmodule
